FILE: rtl/tss_pkg.sv
// Shared types and fixed-point constants for the Taylor-series sine pipeline.
`default_nettype none

package tss_pkg;

  // Fraction bits of the internal magnitudes.
  localparam int unsigned IntFrac = 50;
  // Fraction bits of the reciprocal constants.
  localparam int unsigned RecipFrac = 62;
  // Width of the internal magnitudes and sums.
  localparam int unsigned DataW = 64;
  // Fraction bits of the output.
  localparam int unsigned OutFrac = 30;

  typedef logic [DataW-1:0] data_t;

  // One item travelling down the chain of cells.
  typedef struct packed {
    logic  valid;
    logic  neg;
    data_t term;
    data_t x2;
    data_t pos_sum;
    data_t neg_sum;
  } cell_data_t;

endpackage

`default_nettype wire

FILE: rtl/tss_mul.sv
// Two-stage 64x64 multiplier built from 32x32 partial products, shifted right.
`default_nettype none

module tss_mul
  import tss_pkg::*;
#(
  parameter int unsigned SHIFT = 50
) (
  input  wire        clk_i,
  input  wire        en_i,
  input  wire data_t a_i,
  input  wire data_t b_i,
  output data_t      p_o
);

  logic [63:0]  pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [127:0] full;
  data_t        p_q;

  // First stage: four independent partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      pp_lh_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      pp_hl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      pp_hh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    end
  end

  // Second stage: combine the partial products and keep the shifted window.
  assign full = {64'd0, pp_ll_q} + {32'd0, pp_lh_q, 32'd0}
              + {32'd0, pp_hl_q, 32'd0} + {pp_hh_q, 64'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= full[SHIFT+63:SHIFT];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/tss_cell.sv
// One series cell: accumulates term k and forms term k+1 over four stages.
`default_nettype none

module tss_cell
  import tss_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  wire cell_data_t in_i,
  output cell_data_t      out_o
);

  localparam logic [127:0] RecipOne = 128'd1 << RecipFrac;
  localparam logic [127:0] Den = 128'((2 * K + 2) * (2 * K + 3));
  localparam data_t        Recip = 64'(RecipOne / Den);

  cell_data_t side_q [4];
  cell_data_t side_d;
  data_t      t1;
  data_t      next_term;

  // Add this cell's term to the sum that matches its sign.
  always_comb begin
    side_d = in_i;
    if (in_i.neg ^ K[0]) begin
      side_d.neg_sum = in_i.neg_sum + in_i.term;
    end else begin
      side_d.pos_sum = in_i.pos_sum + in_i.term;
    end
  end

  // Sideband delay line that follows the two multipliers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        side_q[i] <= '0;
      end
    end else if (en_i) begin
      side_q[0] <= side_d;
      for (int i = 1; i < 4; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Term times the reciprocal of (2k+2)(2k+3).
  tss_mul #(.SHIFT(RecipFrac)) u_mul_recip (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (in_i.term),
    .b_i    (Recip),
    .p_o    (t1)
  );

  // Then times x squared.
  tss_mul #(.SHIFT(IntFrac)) u_mul_x2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (t1),
    .b_i    (side_q[1].x2),
    .p_o    (next_term)
  );

  always_comb begin
    out_o      = side_q[3];
    out_o.term = next_term;
  end

endmodule

`default_nettype wire

FILE: rtl/taylor_series_sine_top.sv
// Top level of the Taylor-series sine pipeline.
// Takes one angle per cycle and gives one sine per cycle. The pipeline has three
// front stages (clamp, x squared), four per series cell (two two-stage multipliers)
// for each of the TERMS-1 cells, and two back stages (final sum, then rounding and
// saturation into the output register). The whole pipeline advances whenever the
// output register is empty or being read, so an output stall holds every stage in
// place.
`default_nettype none

module taylor_series_sine_top
  import tss_pkg::*;
#(
  parameter int unsigned TERMS      = 16,
  parameter int unsigned ANGLE_FRAC = 28
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [31:0] angle_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] sine_o
);

  // With 30 or more fraction bits no angle can exceed eight, so no clamp applies.
  localparam logic [32:0] AngleLim = (ANGLE_FRAC >= 30) ? 33'h1_FFFF_FFFF
                                                        : (33'd1 << (ANGLE_FRAC + 3));

  logic        en;
  logic [32:0] mag;
  logic [32:0] mag_clamped;
  cell_data_t  front_q [3];
  data_t       x2;
  cell_data_t  chain [TERMS];
  cell_data_t  last_in;
  logic        sum_valid_q;
  logic        sum_neg_q;
  data_t       sum_diff_q;
  data_t       pos_fin;
  data_t       neg_fin;
  logic [43:0] rounded;
  logic        out_valid_q;
  logic [31:0] sine_q;
  logic [31:0] sine_d;

  // The pipeline moves when the output register can take a new result.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Magnitude of the angle, clamped to eight.
  assign mag         = angle_i[31] ? (33'h1_0000_0000 - {1'b0, angle_i}) : {1'b0, angle_i};
  assign mag_clamped = (mag > AngleLim) ? AngleLim : mag;

  // Front stages: entry register, then the pipelined x squared multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        front_q[i] <= '0;
      end
    end else if (en) begin
      front_q[0].valid   <= in_valid_i;
      front_q[0].neg     <= angle_i[31];
      front_q[0].term    <= 64'(mag_clamped) << (IntFrac - ANGLE_FRAC);
      front_q[0].x2      <= '0;
      front_q[0].pos_sum <= '0;
      front_q[0].neg_sum <= '0;
      front_q[1]         <= front_q[0];
      front_q[2]         <= front_q[1];
    end
  end

  tss_mul #(.SHIFT(IntFrac)) u_mul_sq (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (front_q[0].term),
    .b_i    (front_q[0].term),
    .p_o    (x2)
  );

  always_comb begin
    chain[0]    = front_q[2];
    chain[0].x2 = x2;
  end

  // Row of series cells, one per term that needs a successor, i.e. all but the last.
  for (genvar k = 0; k < TERMS - 1; k++) begin : g_cell
    tss_cell #(.K(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (chain[k]),
      .out_o  (chain[k+1])
    );
  end

  assign last_in = chain[TERMS-1];

  // Add the last term and form the signed difference of the two sums.
  always_comb begin
    pos_fin = last_in.pos_sum;
    neg_fin = last_in.neg_sum;
    if (last_in.neg ^ TERMS[0] ^ 1'b1) begin
      neg_fin = last_in.neg_sum + last_in.term;
    end else begin
      pos_fin = last_in.pos_sum + last_in.term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (en) begin
      sum_valid_q <= last_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_neg_q  <= pos_fin < neg_fin;
      sum_diff_q <= (pos_fin >= neg_fin) ? (pos_fin - neg_fin) : (neg_fin - pos_fin);
    end
  end

  // Round half away from zero to Q2.30 and saturate.
  assign rounded = 44'((sum_diff_q + (64'd1 << (IntFrac - OutFrac - 1)))
                       >> (IntFrac - OutFrac));

  always_comb begin
    if (sum_neg_q) begin
      if (rounded > 44'h0_8000_0000) begin
        sine_d = 32'h8000_0000;
      end else begin
        sine_d = 32'(45'h1_0000_0000 - {1'b0, rounded});
      end
    end else begin
      if (rounded > 44'h0_7FFF_FFFF) begin
        sine_d = 32'h7FFF_FFFF;
      end else begin
        sine_d = rounded[31:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sine_q <= sine_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sine_o      = sine_q;

  // A stalled pipeline must be caused by a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending output transaction");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sine_o))
    else $error("pending output transaction changed while stalled");

  // The final sum stage never loses a result while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q && !en |=> sum_valid_q)
    else $error("final sum stage dropped a transaction during a stall");

endmodule

`default_nettype wire

FILE: tb/sv/taylor_series_sine_checker.sv
// Checker for the sine pipeline: predicts each sine from the accepted angle and compares.
`timescale 1ns / 1ps

module taylor_series_sine_checker
  import tss_pkg::*;
#(
  parameter int unsigned TERMS      = 16,
  parameter int unsigned ANGLE_FRAC = 28
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_ready_i,
  input  wire signed [31:0] angle_i,
  input  wire               out_valid_i,
  input  wire               out_ready_i,
  input  wire signed [31:0] sine_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                sine_seen_o
);

  // With 30 or more fraction bits no angle can exceed eight, so no clamp applies.
  localparam logic [32:0] AngleLim = (ANGLE_FRAC >= 30) ? 33'h1_FFFF_FFFF
                                                        : (33'd1 << (ANGLE_FRAC + 3));

  logic [31:0] sine_queue[$];

  // Sine of one angle by the truncated series, on unsigned magnitudes.
  function automatic logic [31:0] sine_of(logic [31:0] raw);
    logic          neg;
    logic          rneg;
    logic [32:0]   mag;
    logic [63:0]   term;
    logic [63:0]   x2;
    logic [63:0]   pos;
    logic [63:0]   negsum;
    logic [63:0]   recip;
    logic [63:0]   res;
    logic [127:0]  prod;
    pos    = '0;
    negsum = '0;
    neg    = raw[31];
    mag    = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    if (mag > AngleLim) mag = AngleLim;
    term = 64'(mag) << (IntFrac - ANGLE_FRAC);
    prod = 128'(term) * 128'(term);
    x2   = 64'(prod >> IntFrac);
    for (int k = 0; k < TERMS; k++) begin
      if (neg != k[0]) negsum += term;
      else pos += term;
      if (k + 1 < TERMS) begin
        recip = (64'd1 << RecipFrac) / 64'((2 * k + 2) * (2 * k + 3));
        prod  = 128'(term) * 128'(recip);
        term  = 64'(prod >> RecipFrac);
        prod  = 128'(term) * 128'(x2);
        term  = 64'(prod >> IntFrac);
      end
    end
    rneg = pos < negsum;
    res  = rneg ? negsum - pos : pos - negsum;
    res  = (res + (64'd1 << (IntFrac - 31))) >> (IntFrac - OutFrac);
    if (rneg) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      return 32'(64'h1_0000_0000 - res);
    end else begin
      if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
      return res[31:0];
    end
  endfunction

  assign pending_o = sine_queue.size();

  // Queue a prediction per input transaction and check each output transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      sine_seen_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        sine_seen_o <= sine_seen_o + 1;
        if (sine_queue.size() == 0) begin
          $display("%0t: unexpected sine, expected none, actual %h", $time, sine_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = sine_queue.pop_front();
          if (want !== sine_i) begin
            $display("%0t: sine mismatch, expected %h, actual %h", $time, want, sine_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) sine_queue.push_back(sine_of(angle_i));
    end
  end

endmodule

FILE: tb/sv/taylor_series_sine_top_tb.sv
// Testbench top: drives angles and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module taylor_series_sine_top_tb;

  localparam int unsigned TERMS      = 16;
  localparam int unsigned ANGLE_FRAC = 28;
  localparam int          RandomAngles = 1150;
  localparam int          StallLimit   = 5000;
  localparam int          Latency      = 4 * TERMS + 2;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] angle_i = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] sine_o;
  int                 fail_count;
  int                 pending;
  int                 sine_seen;
  int                 idle_cycles = 0;
  logic               calm = 1'b0;
  logic [31:0]        directed_angles[$];

  always #10 clk_i = ~clk_i;

  taylor_series_sine_top #(.TERMS(TERMS), .ANGLE_FRAC(ANGLE_FRAC)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .angle_i,
    .out_valid_o, .out_ready_i, .sine_o
  );

  taylor_series_sine_checker #(.TERMS(TERMS), .ANGLE_FRAC(ANGLE_FRAC)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .angle_i,
    .out_valid_i(out_valid_o), .out_ready_i, .sine_i(sine_o),
    .fail_count_o(fail_count), .pending_o(pending), .sine_seen_o(sine_seen)
  );

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 36);
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one angle, with a possible random gap, and hold it until accepted.
  task automatic send_angle(logic [31:0] value);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i    <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] pick;
    int          bias;
    // Extremes, zero, small values, near pi and the edges of the range.
    directed_angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0001, 32'h1000_0000, 32'hF000_0000,
                        32'h1921_FB54, 32'h3243_F6A9, 32'hCDBC_0957, 32'h6487_ED51,
                        32'h4B65_F1FE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0800_0000,
                        32'h7000_0000, 32'h9000_0000, 32'h0000_FFFF, 32'hFFFF_0000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_angles[i]) send_angle(directed_angles[i]);
    // Random angles: mostly uniform, some small, with a calm stretch in the middle.
    for (int n = 0; n < RandomAngles; n++) begin
      calm <= (n >= 500 && n < 650);
      bias = $urandom_range(9);
      pick = $urandom();
      if (bias < 2) pick = $signed(pick) >>> $urandom_range(31);
      send_angle(pick);
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Covered %0d sines over the full angle range, incl. extremes and stalls.",
             sine_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
